### hw/rtl/rv32i_decode_execute_unit_macros.svh
// Assertion macros shared by the RV32I decode/execute unit.
// Holds only macro definitions; it depends on nothing else.
`ifndef RV32I_DECODE_EXECUTE_UNIT_MACROS_SVH
`define RV32I_DECODE_EXECUTE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVDE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RVDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rvde_pkg.sv
// Shared types and constants of the RV32I decode/execute unit.
// Depends on nothing; every RTL module imports it.
package rvde_pkg;

    typedef enum logic [5:0] {
        K_ADD, K_SUB, K_AND, K_OR, K_XOR, K_SLL, K_SRL, K_SRA, K_SLT, K_SLTU,
        K_ADDI, K_SLTI, K_SLTIU, K_XORI, K_ORI, K_ANDI, K_SLLI, K_SRLI, K_SRAI,
        K_LB, K_LH, K_LW, K_LBU, K_LHU, K_SB, K_SH, K_SW,
        K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
        K_LUI, K_AUIPC, K_JAL, K_JALR, K_HALT
    } t_kind;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_SLL, ALU_SRL, ALU_SRA,
        ALU_SLT, ALU_LTU, ALU_ZERO
    } t_alu_op;

    typedef enum logic [2:0] {
        BR_NONE, BR_EQ, BR_NE, BR_LT, BR_GE, BR_LTU, BR_GEU
    } t_br_op;

    localparam logic [31:0] HALT_WORD  = 32'h0ff0_0513;
    localparam logic [6:0]  OPC_OP     = 7'h33;
    localparam logic [6:0]  OPC_OPIMM  = 7'h13;
    localparam logic [6:0]  OPC_LOAD   = 7'h03;
    localparam logic [6:0]  OPC_STORE  = 7'h23;
    localparam logic [6:0]  OPC_BRANCH = 7'h63;
    localparam logic [6:0]  OPC_LUI    = 7'h37;
    localparam logic [6:0]  OPC_AUIPC  = 7'h17;
    localparam logic [6:0]  OPC_JAL    = 7'h6F;
    localparam logic [6:0]  OPC_JALR   = 7'h67;
    localparam logic [6:0]  F7_ZERO    = 7'h00;
    localparam logic [6:0]  F7_ALT     = 7'h20;
    localparam logic [1:0]  CYC_MEM    = 2'd3;
    localparam logic [1:0]  CYC_ONE    = 2'd1;
    localparam logic [31:0] LINK_STEP  = 32'd4;

    // Decoded fields that travel down the pipeline with each instruction.
    typedef struct packed {
        t_kind       kind;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic        halt;
        logic [1:0]  cycles;
    } t_dec;

    // Operands that travel alongside the decoded fields.
    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] a;
        logic [31:0] b;
    } t_opnd;

endpackage

### hw/rtl/rvde_decode.sv
// First pipeline stage: instruction decode and immediate generation.
// Depends on rvde_pkg.
module rvde_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [31:0]          i_word,
    input  rvde_pkg::t_opnd      i_opnd,
    output logic                 o_valid,
    output rvde_pkg::t_dec       o_dec,
    output rvde_pkg::t_opnd      o_opnd
);
    import rvde_pkg::*;

    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    t_dec       n_dec;
    logic       r_valid;
    t_dec       r_dec;
    t_opnd      r_opnd;

    assign opc = i_word[6:0];
    assign f3  = i_word[14:12];
    assign f7  = i_word[31:25];

    always_comb begin
        n_dec.kind = K_ADD;
        unique case (opc)
            OPC_OP: begin
                if (f7 == F7_ZERO) begin
                    unique case (f3)
                        3'd0: n_dec.kind = K_ADD;
                        3'd1: n_dec.kind = K_SLL;
                        3'd2: n_dec.kind = K_SLT;
                        3'd3: n_dec.kind = K_SLTU;
                        3'd4: n_dec.kind = K_XOR;
                        3'd5: n_dec.kind = K_SRL;
                        3'd6: n_dec.kind = K_OR;
                        default: n_dec.kind = K_AND;
                    endcase
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    n_dec.kind = K_SUB;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    n_dec.kind = K_SRA;
                end
            end
            OPC_OPIMM: begin
                unique case (f3)
                    3'd0: n_dec.kind = K_ADDI;
                    3'd1: n_dec.kind = K_SLLI;
                    3'd2: n_dec.kind = K_SLTI;
                    3'd3: n_dec.kind = K_SLTIU;
                    3'd4: n_dec.kind = K_XORI;
                    3'd5: n_dec.kind = (f7 != F7_ZERO) ? K_SRAI : K_SRLI;
                    3'd6: n_dec.kind = K_ORI;
                    default: n_dec.kind = K_ANDI;
                endcase
            end
            OPC_LOAD: begin
                unique case (f3)
                    3'd0: n_dec.kind = K_LB;
                    3'd1: n_dec.kind = K_LH;
                    3'd2: n_dec.kind = K_LW;
                    3'd4: n_dec.kind = K_LBU;
                    3'd5: n_dec.kind = K_LHU;
                    default: n_dec.kind = K_ADD;
                endcase
            end
            OPC_STORE: begin
                unique case (f3)
                    3'd0: n_dec.kind = K_SB;
                    3'd1: n_dec.kind = K_SH;
                    3'd2: n_dec.kind = K_SW;
                    default: n_dec.kind = K_ADD;
                endcase
            end
            OPC_BRANCH: begin
                unique case (f3)
                    3'd0: n_dec.kind = K_BEQ;
                    3'd1: n_dec.kind = K_BNE;
                    3'd4: n_dec.kind = K_BLT;
                    3'd5: n_dec.kind = K_BGE;
                    3'd6: n_dec.kind = K_BLTU;
                    3'd7: n_dec.kind = K_BGEU;
                    default: n_dec.kind = K_ADD;
                endcase
            end
            OPC_LUI:   n_dec.kind = K_LUI;
            OPC_AUIPC: n_dec.kind = K_AUIPC;
            OPC_JAL:   n_dec.kind = K_JAL;
            OPC_JALR:  n_dec.kind = K_JALR;
            default:   n_dec.kind = K_ADD;
        endcase
        if (i_word == HALT_WORD) begin
            n_dec.kind = K_HALT;
        end

        // The immediate follows the opcode alone, even for the halt word.
        unique case (opc)
            OPC_OPIMM, OPC_LOAD, OPC_JALR:
                n_dec.imm = {{20{i_word[31]}}, i_word[31:20]};
            OPC_STORE:
                n_dec.imm = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
            OPC_BRANCH:
                n_dec.imm = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                             i_word[11:8], 1'b0};
            OPC_LUI, OPC_AUIPC:
                n_dec.imm = {i_word[31:12], 12'h000};
            OPC_JAL:
                n_dec.imm = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                             i_word[30:21], 1'b0};
            default:
                n_dec.imm = 32'd0;
        endcase

        n_dec.rd     = i_word[11:7];
        n_dec.rs1    = i_word[19:15];
        n_dec.rs2    = i_word[24:20];
        n_dec.halt   = (i_word == HALT_WORD);
        n_dec.cycles = (n_dec.kind >= K_LB && n_dec.kind <= K_SW) ? CYC_MEM : CYC_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dec  <= n_dec;
        r_opnd <= i_opnd;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
    assign o_opnd  = r_opnd;

endmodule

### hw/rtl/rvde_exec.sv
// Second and third pipeline stages: operand selection, then ALU and branch compare.
// Depends on rvde_pkg.
module rvde_exec (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  rvde_pkg::t_dec       i_dec,
    input  rvde_pkg::t_opnd      i_opnd,
    output logic                 o_valid,
    output rvde_pkg::t_dec       o_dec,
    output logic [31:0]          o_result,
    output logic                 o_taken
);
    import rvde_pkg::*;

    t_alu_op     n_alu_op;
    t_br_op      n_br_op;
    logic [31:0] n_opa;
    logic [31:0] n_opb;
    logic        r_s2_valid;
    t_dec        r_s2_dec;
    t_alu_op     r_s2_alu_op;
    t_br_op      r_s2_br_op;
    logic [31:0] r_s2_opa;
    logic [31:0] r_s2_opb;
    logic [4:0]  shamt;
    logic [31:0] n_result;
    logic        n_taken;
    logic        lt_s;
    logic        lt_u;
    logic        r_s3_valid;
    t_dec        r_s3_dec;
    logic [31:0] r_s3_result;
    logic        r_s3_taken;

    // Stage two: map the kind onto an ALU operation and pick the operands.
    always_comb begin
        n_alu_op = ALU_ZERO;
        n_br_op  = BR_NONE;
        n_opa    = i_opnd.a;
        n_opb    = i_opnd.b;
        unique case (i_dec.kind)
            K_ADD:   n_alu_op = ALU_ADD;
            K_SUB:   n_alu_op = ALU_SUB;
            K_AND:   n_alu_op = ALU_AND;
            K_OR:    n_alu_op = ALU_OR;
            K_XOR:   n_alu_op = ALU_XOR;
            K_SLL:   n_alu_op = ALU_SLL;
            K_SRL:   n_alu_op = ALU_SRL;
            K_SRA:   n_alu_op = ALU_SRA;
            K_SLT:   n_alu_op = ALU_SLT;
            K_SLTU:  n_alu_op = ALU_LTU;
            K_ADDI:  begin n_alu_op = ALU_ADD;  n_opb = i_dec.imm; end
            K_SLTI:  begin n_alu_op = ALU_SLT;  n_opb = i_dec.imm; end
            K_SLTIU: begin n_alu_op = ALU_LTU;  n_opb = i_dec.imm; end
            K_XORI:  begin n_alu_op = ALU_XOR;  n_opb = i_dec.imm; end
            K_ORI:   begin n_alu_op = ALU_OR;   n_opb = i_dec.imm; end
            K_ANDI:  begin n_alu_op = ALU_AND;  n_opb = i_dec.imm; end
            K_SLLI:  begin n_alu_op = ALU_SLL;  n_opb = i_dec.imm; end
            K_SRLI:  begin n_alu_op = ALU_SRL;  n_opb = i_dec.imm; end
            K_SRAI:  begin n_alu_op = ALU_SRA;  n_opb = i_dec.imm; end
            K_BEQ:   n_br_op = BR_EQ;
            K_BNE:   n_br_op = BR_NE;
            K_BLT:   n_br_op = BR_LT;
            K_BGE:   n_br_op = BR_GE;
            K_BLTU:  n_br_op = BR_LTU;
            K_BGEU:  n_br_op = BR_GEU;
            K_LUI:   begin n_alu_op = ALU_ADD; n_opa = 32'd0; n_opb = i_dec.imm; end
            K_AUIPC: begin n_alu_op = ALU_ADD; n_opa = i_opnd.pc; n_opb = i_dec.imm; end
            K_JAL, K_JALR: begin
                n_alu_op = ALU_ADD;
                n_opa    = i_opnd.pc;
                n_opb    = LINK_STEP;
            end
            default: n_alu_op = ALU_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_valid;
        end
        r_s2_dec    <= i_dec;
        r_s2_alu_op <= n_alu_op;
        r_s2_br_op  <= n_br_op;
        r_s2_opa    <= n_opa;
        r_s2_opb    <= n_opb;
    end

    // Stage three: the ALU proper and the branch condition.
    assign shamt = r_s2_opb[4:0];
    assign lt_s  = $signed(r_s2_opa) < $signed(r_s2_opb);
    assign lt_u  = r_s2_opa < r_s2_opb;

    always_comb begin
        unique case (r_s2_alu_op)
            ALU_ADD:  n_result = r_s2_opa + r_s2_opb;
            ALU_SUB:  n_result = r_s2_opa - r_s2_opb;
            ALU_AND:  n_result = r_s2_opa & r_s2_opb;
            ALU_OR:   n_result = r_s2_opa | r_s2_opb;
            ALU_XOR:  n_result = r_s2_opa ^ r_s2_opb;
            ALU_SLL:  n_result = r_s2_opa << shamt;
            ALU_SRL:  n_result = r_s2_opa >> shamt;
            ALU_SRA:  n_result = $unsigned($signed(r_s2_opa) >>> shamt);
            ALU_SLT:  n_result = {31'd0, lt_s};
            ALU_LTU:  n_result = {31'd0, lt_u};
            default:  n_result = 32'd0;
        endcase
        unique case (r_s2_br_op)
            BR_EQ:   n_taken = (r_s2_opa == r_s2_opb);
            BR_NE:   n_taken = (r_s2_opa != r_s2_opb);
            BR_LT:   n_taken = lt_s;
            BR_GE:   n_taken = !lt_s;
            BR_LTU:  n_taken = lt_u;
            BR_GEU:  n_taken = !lt_u;
            default: n_taken = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_dec    <= r_s2_dec;
        r_s3_result <= n_result;
        r_s3_taken  <= n_taken;
    end

    assign o_valid  = r_s3_valid;
    assign o_dec    = r_s3_dec;
    assign o_result = r_s3_result;
    assign o_taken  = r_s3_taken;

endmodule

### hw/rtl/rv32i_decode_execute_unit.sv
// Top level of the RV32I decode/execute unit: three-stage decode and ALU pipeline.
// Depends on rvde_pkg, rvde_decode, rvde_exec and rv32i_decode_execute_unit_macros.svh.
//
// Usage:
// The requester presents an instruction word, its pc and the two source
// register values, and raises start. A transaction is accepted at each rising
// edge where start is high and busy is low. Busy is high only during reset and
// until r_live is set after it; then the unit takes one instruction every cycle.
// The pipeline has three register stages: decode and immediate generation,
// operand selection, then the ALU and branch compare. Each result appears on
// the o_ ports from the last stage register and is marked by o_done for a
// single cycle; results leave in acceptance order. The receiver cannot hold
// results off, and nothing inside the unit ever waits, so there is no stall
// path: the valid bits simply shift every cycle. Throughput is one instruction
// per cycle, with the 32-bit adder and barrel shifter in the last stage.
// Reset is synchronous and active low. It clears the stage valid bits, so any
// instruction in flight is dropped and no o_done pulse follows reset.
module rv32i_decode_execute_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [31:0]  i_instruction_word,
    input  logic [31:0]  i_program_counter,
    input  logic [31:0]  i_first_operand,
    input  logic [31:0]  i_second_operand,
    output logic         o_done,
    output logic [5:0]   o_instr_kind,
    output logic [4:0]   o_dest_index,
    output logic [4:0]   o_src1_index,
    output logic [4:0]   o_src2_index,
    output logic signed [31:0] o_immediate,
    output logic [31:0]  o_alu_result,
    output logic         o_branch_taken,
    output logic         o_halt_flag,
    output logic [1:0]   o_exec_cycles
);
    import rvde_pkg::*;

`include "rv32i_decode_execute_unit_macros.svh"

    // Set in the cycle after reset is released; the unit refuses transactions
    // until then.
    logic        r_live;
    logic        accept;
    t_opnd       in_opnd;
    logic        s1_valid;
    t_dec        s1_dec;
    t_opnd       s1_opnd;
    logic        s3_valid;
    t_dec        s3_dec;
    logic [31:0] s3_result;
    logic        s3_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign busy   = !r_live;
    assign accept = start && r_live;

    assign in_opnd.pc = i_program_counter;
    assign in_opnd.a  = i_first_operand;
    assign in_opnd.b  = i_second_operand;

    rvde_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_word  (i_instruction_word),
        .i_opnd  (in_opnd),
        .o_valid (s1_valid),
        .o_dec   (s1_dec),
        .o_opnd  (s1_opnd)
    );

    rvde_exec u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .i_dec    (s1_dec),
        .i_opnd   (s1_opnd),
        .o_valid  (s3_valid),
        .o_dec    (s3_dec),
        .o_result (s3_result),
        .o_taken  (s3_taken)
    );

    assign o_done         = s3_valid;
    assign o_instr_kind   = s3_dec.kind;
    assign o_dest_index   = s3_dec.rd;
    assign o_src1_index   = s3_dec.rs1;
    assign o_src2_index   = s3_dec.rs2;
    assign o_immediate    = $signed(s3_dec.imm);
    assign o_alu_result   = s3_result;
    assign o_branch_taken = s3_taken;
    assign o_halt_flag    = s3_dec.halt;
    assign o_exec_cycles  = s3_dec.cycles;

    // A transaction accepted now sits in the decode stage register in the next cycle.
    `RVDE_ASSERT_NEXT(a_s1_follows_accept, i_clk, i_rst_n, accept, s1_valid,
        "accepted transaction lost in decode stage")
    // The halt word never produces an ALU value.
    `RVDE_ASSERT_SAME(a_halt_zero, i_clk, i_rst_n, o_done && o_halt_flag,
        (o_alu_result == 32'd0) && (s3_dec.kind == K_HALT),
        "halt result carries ALU value or wrong kind")
    // Only loads and stores carry the memory cycle count, and they produce no ALU value.
    `RVDE_ASSERT_SAME(a_mem_cycles, i_clk, i_rst_n, o_done && (o_exec_cycles == CYC_MEM),
        (s3_dec.kind >= K_LB) && (s3_dec.kind <= K_SW) && (o_alu_result == 32'd0),
        "memory cycle count on a non-memory kind")
    // A taken branch must be a branch kind.
    `RVDE_ASSERT_SAME(a_taken_branch, i_clk, i_rst_n, o_done && o_branch_taken,
        (s3_dec.kind >= K_BEQ) && (s3_dec.kind <= K_BGEU),
        "branch taken on a non-branch kind")

endmodule

### test/rv32i_decode_execute_unit_tb.sv
// Self-checking testbench for rv32i_decode_execute_unit: directed and random instruction streams.
// Depends on rvde_pkg and the unit's RTL; expected results come from a behavioral decoder below.
module rv32i_decode_execute_unit_tb;
    import rvde_pkg::*;

    // Field codes for funct3 grouped by the instruction class that uses them, and an odd funct7.
    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4, F3_SRL = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
    localparam logic [2:0] F3_B = 3'd0, F3_H = 3'd1, F3_W = 3'd2, F3_BU = 3'd4, F3_HU = 3'd5;
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
    localparam logic [2:0] F3_LD_UNUSED = 3'd6, F3_ST_UNUSED = 3'd3, F3_BR_UNUSED = 3'd2;
    localparam logic [6:0] F7_ODD = 7'h01;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED = 40;

    // One expected result, plus the instruction word that caused it for messages.
    typedef struct packed {
        logic [31:0] word;
        t_kind       kind;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] alu;
        logic        taken;
        logic        halt;
        logic [1:0]  cycles;
    } t_instr_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_instruction_word;
    logic [31:0] i_program_counter;
    logic [31:0] i_first_operand;
    logic [31:0] i_second_operand;
    logic        o_done;
    logic [5:0]  o_instr_kind;
    logic [4:0]  o_dest_index;
    logic [4:0]  o_src1_index;
    logic [4:0]  o_src2_index;
    logic signed [31:0] o_immediate;
    logic [31:0] o_alu_result;
    logic        o_branch_taken;
    logic        o_halt_flag;
    logic [1:0]  o_exec_cycles;

    t_instr_outcome expected_outcomes[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    // Percentage chance that the sender leaves a gap before a transaction.
    int gap_percent = 0;

    rv32i_decode_execute_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_instruction_word (i_instruction_word),
        .i_program_counter  (i_program_counter),
        .i_first_operand    (i_first_operand),
        .i_second_operand   (i_second_operand),
        .o_done             (o_done),
        .o_instr_kind       (o_instr_kind),
        .o_dest_index       (o_dest_index),
        .o_src1_index       (o_src1_index),
        .o_src2_index       (o_src2_index),
        .o_immediate        (o_immediate),
        .o_alu_result       (o_alu_result),
        .o_branch_taken     (o_branch_taken),
        .o_halt_flag        (o_halt_flag),
        .o_exec_cycles      (o_exec_cycles)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Behavioral decoder and ALU. The exact halt word overrides every other decoding,
    // and other non-RV32I words fall back to ADD, though immediate shifts take any funct7.
    function automatic t_instr_outcome decode_and_execute(input logic [31:0] w,
            input logic [31:0] pc, input logic [31:0] a, input logic [31:0] b);
        t_instr_outcome r;
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
        opc = w[6:0];
        f3 = w[14:12];
        f7 = w[31:25];
        r.word = w;
        r.rd = w[11:7];
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        r.kind = K_ADD;
        case (opc)
            OPC_OP: begin
                if (f7 == F7_ZERO) begin
                    case (f3)
                        F3_ADD:  r.kind = K_ADD;
                        F3_SLL:  r.kind = K_SLL;
                        F3_SLT:  r.kind = K_SLT;
                        F3_SLTU: r.kind = K_SLTU;
                        F3_XOR:  r.kind = K_XOR;
                        F3_SRL:  r.kind = K_SRL;
                        F3_OR:   r.kind = K_OR;
                        default: r.kind = K_AND;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    r.kind = K_SUB;
                end else if (f7 == F7_ALT && f3 == F3_SRL) begin
                    r.kind = K_SRA;
                end
            end
            OPC_OPIMM: begin
                case (f3)
                    F3_ADD:  r.kind = K_ADDI;
                    F3_SLL:  r.kind = K_SLLI;
                    F3_SLT:  r.kind = K_SLTI;
                    F3_SLTU: r.kind = K_SLTIU;
                    F3_XOR:  r.kind = K_XORI;
                    // Any nonzero funct7 selects the arithmetic shift.
                    F3_SRL:  r.kind = (f7 != F7_ZERO) ? K_SRAI : K_SRLI;
                    F3_OR:   r.kind = K_ORI;
                    default: r.kind = K_ANDI;
                endcase
            end
            OPC_LOAD: begin
                case (f3)
                    F3_B:  r.kind = K_LB;
                    F3_H:  r.kind = K_LH;
                    F3_W:  r.kind = K_LW;
                    F3_BU: r.kind = K_LBU;
                    F3_HU: r.kind = K_LHU;
                    default: r.kind = K_ADD;
                endcase
            end
            OPC_STORE: begin
                case (f3)
                    F3_B: r.kind = K_SB;
                    F3_H: r.kind = K_SH;
                    F3_W: r.kind = K_SW;
                    default: r.kind = K_ADD;
                endcase
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  r.kind = K_BEQ;
                    F3_BNE:  r.kind = K_BNE;
                    F3_BLT:  r.kind = K_BLT;
                    F3_BGE:  r.kind = K_BGE;
                    F3_BLTU: r.kind = K_BLTU;
                    F3_BGEU: r.kind = K_BGEU;
                    default: r.kind = K_ADD;
                endcase
            end
            OPC_LUI:   r.kind = K_LUI;
            OPC_AUIPC: r.kind = K_AUIPC;
            OPC_JAL:   r.kind = K_JAL;
            OPC_JALR:  r.kind = K_JALR;
            default:   r.kind = K_ADD;
        endcase
        if (w == HALT_WORD) r.kind = K_HALT;

        // The immediate follows the opcode alone, even for undecodable words.
        case (opc)
            OPC_OPIMM, OPC_LOAD, OPC_JALR: r.imm = {{20{w[31]}}, w[31:20]};
            OPC_STORE:  r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            OPC_BRANCH: r.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            OPC_LUI, OPC_AUIPC: r.imm = {w[31:12], 12'b0};
            OPC_JAL:    r.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default:    r.imm = '0;
        endcase

        case (r.kind)
            K_ADD:   r.alu = a + b;
            K_SUB:   r.alu = a - b;
            K_AND:   r.alu = a & b;
            K_OR:    r.alu = a | b;
            K_XOR:   r.alu = a ^ b;
            K_SLL:   r.alu = a << b[4:0];
            K_SRL:   r.alu = a >> b[4:0];
            K_SRA:   r.alu = $signed(a) >>> b[4:0];
            K_SLT:   r.alu = {31'b0, $signed(a) < $signed(b)};
            K_SLTU:  r.alu = {31'b0, a < b};
            K_ADDI:  r.alu = a + r.imm;
            K_SLTI:  r.alu = {31'b0, $signed(a) < $signed(r.imm)};
            K_SLTIU: r.alu = {31'b0, a < r.imm};
            K_XORI:  r.alu = a ^ r.imm;
            K_ORI:   r.alu = a | r.imm;
            K_ANDI:  r.alu = a & r.imm;
            K_SLLI:  r.alu = a << r.imm[4:0];
            K_SRLI:  r.alu = a >> r.imm[4:0];
            K_SRAI:  r.alu = $signed(a) >>> r.imm[4:0];
            K_LUI:   r.alu = r.imm;
            K_AUIPC: r.alu = pc + r.imm;
            K_JAL, K_JALR: r.alu = pc + LINK_STEP;
            default: r.alu = '0;
        endcase

        case (r.kind)
            K_BEQ:   r.taken = (a == b);
            K_BNE:   r.taken = (a != b);
            K_BLT:   r.taken = ($signed(a) < $signed(b));
            K_BGE:   r.taken = !($signed(a) < $signed(b));
            K_BLTU:  r.taken = (a < b);
            K_BGEU:  r.taken = (a >= b);
            default: r.taken = 1'b0;
        endcase

        r.halt = (r.kind == K_HALT);
        case (r.kind)
            K_LB, K_LH, K_LW, K_LBU, K_LHU, K_SB, K_SH, K_SW: r.cycles = CYC_MEM;
            default: r.cycles = CYC_ONE;
        endcase
        return r;
    endfunction

    // Builds a well-formed word of the given kind; the register fields, the immediate
    // bits and every field the kind ignores are random. K_HALT gives the halt word.
    function automatic logic [31:0] random_word_of(input t_kind k);
        logic [31:0] w;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        w = $urandom;
        f3 = w[14:12];
        f7 = w[31:25];
        opc = OPC_OP;
        case (k)
            K_ADD:   begin f3 = F3_ADD;  f7 = F7_ZERO; end
            K_SUB:   begin f3 = F3_ADD;  f7 = F7_ALT;  end
            K_AND:   begin f3 = F3_AND;  f7 = F7_ZERO; end
            K_OR:    begin f3 = F3_OR;   f7 = F7_ZERO; end
            K_XOR:   begin f3 = F3_XOR;  f7 = F7_ZERO; end
            K_SLL:   begin f3 = F3_SLL;  f7 = F7_ZERO; end
            K_SRL:   begin f3 = F3_SRL;  f7 = F7_ZERO; end
            K_SRA:   begin f3 = F3_SRL;  f7 = F7_ALT;  end
            K_SLT:   begin f3 = F3_SLT;  f7 = F7_ZERO; end
            K_SLTU:  begin f3 = F3_SLTU; f7 = F7_ZERO; end
            K_ADDI:  begin opc = OPC_OPIMM; f3 = F3_ADD;  end
            K_SLTI:  begin opc = OPC_OPIMM; f3 = F3_SLT;  end
            K_SLTIU: begin opc = OPC_OPIMM; f3 = F3_SLTU; end
            K_XORI:  begin opc = OPC_OPIMM; f3 = F3_XOR;  end
            K_ORI:   begin opc = OPC_OPIMM; f3 = F3_OR;   end
            K_ANDI:  begin opc = OPC_OPIMM; f3 = F3_AND;  end
            K_SLLI:  begin opc = OPC_OPIMM; f3 = F3_SLL;  end
            K_SRLI:  begin opc = OPC_OPIMM; f3 = F3_SRL; f7 = F7_ZERO; end
            K_SRAI: begin
                opc = OPC_OPIMM;
                f3 = F3_SRL;
                // Half the time the standard encoding, otherwise any nonzero funct7.
                if ($urandom_range(0, 1) == 0) f7 = F7_ALT;
                else f7 = 7'($urandom_range(1, 127));
            end
            K_LB:    begin opc = OPC_LOAD;   f3 = F3_B;    end
            K_LH:    begin opc = OPC_LOAD;   f3 = F3_H;    end
            K_LW:    begin opc = OPC_LOAD;   f3 = F3_W;    end
            K_LBU:   begin opc = OPC_LOAD;   f3 = F3_BU;   end
            K_LHU:   begin opc = OPC_LOAD;   f3 = F3_HU;   end
            K_SB:    begin opc = OPC_STORE;  f3 = F3_B;    end
            K_SH:    begin opc = OPC_STORE;  f3 = F3_H;    end
            K_SW:    begin opc = OPC_STORE;  f3 = F3_W;    end
            K_BEQ:   begin opc = OPC_BRANCH; f3 = F3_BEQ;  end
            K_BNE:   begin opc = OPC_BRANCH; f3 = F3_BNE;  end
            K_BLT:   begin opc = OPC_BRANCH; f3 = F3_BLT;  end
            K_BGE:   begin opc = OPC_BRANCH; f3 = F3_BGE;  end
            K_BLTU:  begin opc = OPC_BRANCH; f3 = F3_BLTU; end
            K_BGEU:  begin opc = OPC_BRANCH; f3 = F3_BGEU; end
            K_LUI:   opc = OPC_LUI;
            K_AUIPC: opc = OPC_AUIPC;
            K_JAL:   opc = OPC_JAL;
            K_JALR:  opc = OPC_JALR;
            default: return HALT_WORD;
        endcase
        return {f7, w[24:15], f3, w[11:7], opc};
    endfunction

    // Draws words until one falls back to ADD without being a genuine ADD encoding.
    function automatic logic [31:0] undecodable_word();
        logic [31:0] w;
        int          sel;
        t_instr_outcome probe;
        sel = $urandom_range(0, 4);
        do begin
            w = $urandom;
            case (sel)
                0: w[6:0] = OPC_OP;
                1: w[6:0] = OPC_LOAD;
                2: w[6:0] = OPC_STORE;
                3: w[6:0] = OPC_BRANCH;
                default: ;
            endcase
            probe = decode_and_execute(w, '0, '0, '0);
        end while (probe.kind != K_ADD || (w[6:0] == OPC_OP && w[31:25] == F7_ZERO));
        return w;
    endfunction

    // Operand values lean toward the corners of signed and unsigned compares.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 63);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_pc();
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFC;
            1: return $urandom;
            default: return $urandom & 32'hFFFF_FFFC;
        endcase
    endfunction

    // Drives one transaction and returns at the edge where it is accepted. An idle gap
    // may come first; during a gap the instruction word and first operand carry junk.
    task automatic send_instr(input logic [31:0] word, input logic [31:0] pc,
            input logic [31:0] a, input logic [31:0] b);
        if ($urandom_range(0, 99) < gap_percent) begin
            start <= 1'b0;
            i_instruction_word <= $urandom;
            i_first_operand <= $urandom;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_instruction_word <= word;
        i_program_counter <= pc;
        i_first_operand <= a;
        i_second_operand <= b;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic send_with_random_operands(input logic [31:0] word);
        logic [31:0] a;
        a = pick_operand();
        // Equal operands now and then so that the equality branches are taken.
        send_instr(word, pick_pc(), a, ($urandom_range(0, 3) == 0) ? a : pick_operand());
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] word,
            input logic [31:0] got, input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch: %s, word %h at cycle %0d: got %h, expected %h",
                     what, word, cycle_count, got, want);
    endtask

    // Corners of every field and each irregular decoding rule.
    task automatic test_directed_cases();
        gap_percent = 20;
        send_instr(HALT_WORD, 32'h0000_1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // One bit away from the halt word is an ordinary ADDI.
        send_instr(HALT_WORD ^ 32'h0000_0080, 32'h0000_1000, 32'h0000_0001, 32'h0);
        send_instr(32'h0000_0000, 32'h0, 32'h0, 32'h0);
        send_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_instr({F7_ZERO, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP},
                   32'h0, 32'hFFFF_FFFF, 32'h0000_0001);
        send_instr({F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd0, OPC_OP}, 32'h0, 32'h0, 32'h0000_0001);
        // Only the low five bits of the register give the shift amount.
        send_instr({F7_ALT, 5'd4, 5'd3, F3_SRL, 5'd5, OPC_OP},
                   32'h0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_instr({F7_ZERO, 5'd4, 5'd3, F3_SLL, 5'd5, OPC_OP},
                   32'h0, 32'h1234_5678, 32'h0000_0020);
        send_instr({F7_ZERO, 5'd1, 5'd2, F3_SLT, 5'd3, OPC_OP},
                   32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_instr({F7_ZERO, 5'd1, 5'd2, F3_SLTU, 5'd3, OPC_OP},
                   32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
        // A foreign funct7, and the alternate funct7 on an operation without one.
        send_instr({F7_ODD, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OP},
                   32'h0, 32'h0000_0005, 32'h0000_0007);
        send_instr({F7_ALT, 5'd1, 5'd2, F3_AND, 5'd3, OPC_OP},
                   32'h0, 32'hFFFF_FFFF, 32'h0000_0001);
        send_instr({12'hFFF, 5'd1, F3_ADD, 5'd2, OPC_OPIMM}, 32'h0, 32'h7FFF_FFFF, 32'h0);
        send_instr({12'hFFF, 5'd1, F3_SLTU, 5'd2, OPC_OPIMM}, 32'h0, 32'hFFFF_FFFE, 32'h0);
        // Any nonzero funct7 turns a right shift immediate into an arithmetic one.
        send_instr({F7_ODD, 5'd31, 5'd1, F3_SRL, 5'd1, OPC_OPIMM},
                   32'h0, 32'h8000_0000, 32'h0);
        send_instr({F7_ZERO, 5'd0, 5'd1, F3_SRL, 5'd1, OPC_OPIMM},
                   32'h0, 32'h8000_0000, 32'h0);
        send_instr({{7{1'b1}}, 5'd31, 5'd1, F3_SLL, 5'd1, OPC_OPIMM},
                   32'h0, 32'h0000_0001, 32'h0);
        send_instr({12'h800, 5'd2, F3_W, 5'd3, OPC_LOAD}, 32'h0, 32'h1000_0000, 32'h5);
        send_instr({12'h7FF, 5'd2, F3_LD_UNUSED, 5'd3, OPC_LOAD},
                   32'h0, 32'h0000_0003, 32'h0000_0004);
        send_instr({7'h3F, 5'd5, 5'd6, F3_W, 5'h1F, OPC_STORE}, 32'h0, 32'h9, 32'h9);
        send_instr({7'h40, 5'd5, 5'd6, F3_ST_UNUSED, 5'h00, OPC_STORE},
                   32'h0, 32'h0000_0010, 32'h0000_0020);
        send_instr({1'b1, 6'h3F, 5'd2, 5'd1, F3_BEQ, 4'hF, 1'b1, OPC_BRANCH},
                   32'h0, 32'h8000_0000, 32'h8000_0000);
        send_instr({1'b0, 6'h01, 5'd2, 5'd1, F3_BLT, 4'h2, 1'b0, OPC_BRANCH},
                   32'h0, 32'h8000_0000, 32'h0000_0000);
        send_instr({1'b0, 6'h01, 5'd2, 5'd1, F3_BGEU, 4'h2, 1'b1, OPC_BRANCH},
                   32'h0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_instr({1'b1, 6'h00, 5'd2, 5'd1, F3_BR_UNUSED, 4'h0, 1'b0, OPC_BRANCH},
                   32'h0, 32'h0000_0001, 32'h0000_0001);
        send_instr({20'hFFFFF, 5'd7, OPC_LUI}, 32'h0, 32'h0, 32'h0);
        send_instr({20'h00001, 5'd1, OPC_AUIPC}, 32'hFFFF_F000, 32'h0, 32'h0);
        // Link values wrap at the top of the address space; JALR ignores funct3.
        send_instr({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd1, OPC_JAL}, 32'hFFFF_FFFC, 32'h0, 32'h0);
        send_instr({12'h801, 5'd3, 3'b111, 5'd1, OPC_JALR}, 32'hFFFF_FFFC, 32'h0, 32'h0);
    endtask

    // Every kind once, with random content.
    task automatic test_kind_sweep();
        gap_percent = 10;
        for (int k = 0; k <= K_HALT; k++) send_with_random_operands(random_word_of(t_kind'(k)));
    endtask

    // Mostly well-formed instructions, with undecodable words, raw noise and
    // near-halt words mixed in.
    task automatic run_random_mix(input int count, input bit with_gaps);
        logic [31:0] w;
        for (int n = 0; n < count; n++) begin
            if (!with_gaps) begin
                gap_percent = 0;
            end else if (n % 100 == 0) begin
                // Gap density changes in stretches, including stretches with none.
                case ($urandom_range(0, 2))
                    0: gap_percent = 0;
                    1: gap_percent = 8;
                    default: gap_percent = 35;
                endcase
            end
            case ($urandom_range(0, 19))
                14, 15, 16: w = undecodable_word();
                17, 18: w = $urandom;
                19: begin
                    w = HALT_WORD;
                    if ($urandom_range(0, 1) == 0) w = w ^ (32'd1 << $urandom_range(0, 31));
                end
                default: w = random_word_of(t_kind'($urandom_range(0, K_HALT)));
            endcase
            send_with_random_operands(w);
        end
    endtask

    task automatic test_random_mix();
        run_random_mix(1100, 1'b1);
    endtask

    // The closing stretch keeps start high on every cycle.
    task automatic test_back_to_back();
        run_random_mix(100, 1'b0);
    endtask

    // Transaction monitor and result checker. Both sample on the rising edge, when
    // the unit's registered outputs and our nonblocking drives still hold the values
    // of the cycle that just ended. An accepted transaction is predicted first so
    // that a result in the same cycle would still find its expectation.
    always @(posedge i_clk) begin : result_check
        t_instr_outcome want;
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0)
            expected_outcomes.push_back(decode_and_execute(i_instruction_word,
                i_program_counter, i_first_operand, i_second_operand));
        if (o_done === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("result with no transaction pending", 32'h0,
                                o_alu_result, 32'h0);
            end else begin
                want = expected_outcomes.pop_front();
                if (o_instr_kind !== want.kind)
                    report_mismatch("instr_kind", want.word, 32'(o_instr_kind),
                                    32'(want.kind));
                if (o_dest_index !== want.rd)
                    report_mismatch("dest_index", want.word, 32'(o_dest_index),
                                    32'(want.rd));
                if (o_src1_index !== want.rs1)
                    report_mismatch("src1_index", want.word, 32'(o_src1_index),
                                    32'(want.rs1));
                if (o_src2_index !== want.rs2)
                    report_mismatch("src2_index", want.word, 32'(o_src2_index),
                                    32'(want.rs2));
                if (o_immediate !== want.imm)
                    report_mismatch("immediate", want.word, o_immediate, want.imm);
                if (o_alu_result !== want.alu)
                    report_mismatch("alu_result", want.word, o_alu_result, want.alu);
                if (o_branch_taken !== want.taken)
                    report_mismatch("branch_taken", want.word, 32'(o_branch_taken),
                                    32'(want.taken));
                if (o_halt_flag !== want.halt)
                    report_mismatch("halt_flag", want.word, 32'(o_halt_flag),
                                    32'(want.halt));
                if (o_exec_cycles !== want.cycles)
                    report_mismatch("exec_cycles", want.word, 32'(o_exec_cycles),
                                    32'(want.cycles));
            end
        end
    end

    // Watchdog: the slowest legal run is far below this many cycles.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_instruction_word <= '0;
        i_program_counter <= '0;
        i_first_operand <= '0;
        i_second_operand <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_kind_sweep();
        test_random_mix();
        test_back_to_back();

        // Let the pipeline drain, then keep watching for stray results.
        start <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_outcomes.size() != 0)
            report_mismatch("results never delivered", 32'h0,
                            32'(expected_outcomes.size()), 32'h0);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
